// ===== src/pidc_pkg.sv =====
// Shared types, register codes and reset values for the clamped PID controller.
package pidc_pkg;

    // Field widths fixed by the sample, gain and limit formats.
    localparam int SAMPLE_W   = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int MODE_W     = 3;
    localparam int INTEG_W    = 32;
    localparam int PROD_W     = 34;
    localparam int PROD_D_W   = 35;
    localparam int PD_W       = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Gain products carry eight fraction bits.
    localparam int GAIN_FRAC = 8;

    // Bit positions inside mode_flags.
    localparam int MODE_ERR_CLAMP  = 0;
    localparam int MODE_INT_CLAMP  = 1;
    localparam int MODE_SEPARATION = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE_FLAGS      = 3'd0,
        REG_ERROR_LIMIT     = 3'd1,
        REG_SEPARATION_BAND = 3'd2,
        REG_INTEGRAL_LIMIT  = 3'd3,
        REG_GAIN_P          = 3'd4,
        REG_GAIN_I          = 3'd5,
        REG_GAIN_D          = 3'd6,
        REG_OUTPUT_LIMIT    = 3'd7
    } reg_index_t;

    // Reset values of the configuration registers.
    localparam logic [MODE_W-1:0]  RST_MODE_FLAGS      = 3'd2;
    localparam logic [LIMIT_W-1:0] RST_ERROR_LIMIT     = 15'd500;
    localparam logic [LIMIT_W-1:0] RST_SEPARATION_BAND = 15'd0;
    localparam logic [LIMIT_W-1:0] RST_INTEGRAL_LIMIT  = 15'd200;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P          = 16'd128;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I          = 16'd640;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D          = 16'd461;
    localparam logic [LIMIT_W-1:0] RST_OUTPUT_LIMIT    = 15'd5000;

    // Full set of configuration registers.
    typedef struct packed {
        logic [MODE_W-1:0]  mode_flags;
        logic [LIMIT_W-1:0] error_limit;
        logic [LIMIT_W-1:0] separation_band;
        logic [LIMIT_W-1:0] integral_limit;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0] output_limit;
    } cfg_t;

    // Registered gain products of one sample, passed to the accumulate stage.
    typedef struct packed {
        logic signed [PROD_W-1:0]   prod_p;
        logic signed [PROD_W-1:0]   prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
        logic                       integrate;
    } prod_t;

endpackage

// ===== src/pidc_cfg_regs.sv =====
// Configuration register file of the clamped PID controller.
module pidc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pidc_pkg::cfg_t                   cfg
);

    pidc_pkg::cfg_t cfg_reg;
    pidc_pkg::cfg_t cfg_next;

    // Decode a write into the addressed register, masking unused data bits.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (pidc_pkg::reg_index_t'(cfg_index))
                pidc_pkg::REG_MODE_FLAGS:
                    cfg_next.mode_flags = cfg_data[pidc_pkg::MODE_W-1:0];
                pidc_pkg::REG_ERROR_LIMIT:
                    cfg_next.error_limit = cfg_data[pidc_pkg::LIMIT_W-1:0];
                pidc_pkg::REG_SEPARATION_BAND:
                    cfg_next.separation_band = cfg_data[pidc_pkg::LIMIT_W-1:0];
                pidc_pkg::REG_INTEGRAL_LIMIT:
                    cfg_next.integral_limit = cfg_data[pidc_pkg::LIMIT_W-1:0];
                pidc_pkg::REG_GAIN_P:
                    cfg_next.gain_p = cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_GAIN_I:
                    cfg_next.gain_i = cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_GAIN_D:
                    cfg_next.gain_d = cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_OUTPUT_LIMIT:
                    cfg_next.output_limit = cfg_data[pidc_pkg::LIMIT_W-1:0];
            endcase
        end
    end

    // Register storage with reset defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_flags      <= pidc_pkg::RST_MODE_FLAGS;
            cfg_reg.error_limit     <= pidc_pkg::RST_ERROR_LIMIT;
            cfg_reg.separation_band <= pidc_pkg::RST_SEPARATION_BAND;
            cfg_reg.integral_limit  <= pidc_pkg::RST_INTEGRAL_LIMIT;
            cfg_reg.gain_p          <= pidc_pkg::RST_GAIN_P;
            cfg_reg.gain_i          <= pidc_pkg::RST_GAIN_I;
            cfg_reg.gain_d          <= pidc_pkg::RST_GAIN_D;
            cfg_reg.output_limit    <= pidc_pkg::RST_OUTPUT_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/pidc_mult_stage.sv =====
// Sample register, error clamp and gain multipliers of the PID controller.
module pidc_mult_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_load,
    input  logic                                  prod_load,
    input  logic signed [pidc_pkg::SAMPLE_W-1:0]  setpoint,
    input  logic signed [pidc_pkg::SAMPLE_W-1:0]  measured,
    input  pidc_pkg::cfg_t                        cfg,
    output pidc_pkg::prod_t                       prod
);

    logic signed [pidc_pkg::SAMPLE_W-1:0] setpoint_reg;
    logic signed [pidc_pkg::SAMPLE_W-1:0] measured_reg;
    logic signed [pidc_pkg::ERR_W-1:0]    prev_err_reg;
    logic signed [pidc_pkg::ERR_W-1:0]    prev_err_next;
    pidc_pkg::prod_t                      prod_reg;
    pidc_pkg::prod_t                      prod_next;

    logic signed [pidc_pkg::ERR_W-1:0]    err_raw;
    logic signed [pidc_pkg::ERR_W-1:0]    err_lim;
    logic signed [pidc_pkg::ERR_W-1:0]    err;
    logic        [pidc_pkg::ERR_W-1:0]    abs_err;
    logic signed [pidc_pkg::DIFF_W-1:0]   err_diff;
    logic signed [pidc_pkg::GAIN_W:0]     gain_p_s;
    logic signed [pidc_pkg::GAIN_W:0]     gain_i_s;
    logic signed [pidc_pkg::GAIN_W:0]     gain_d_s;

    // Error, optional symmetric clamp and the separation test.
    always_comb
    begin
        err_raw = pidc_pkg::ERR_W'(setpoint_reg) - pidc_pkg::ERR_W'(measured_reg);
        err_lim = $signed({2'b00, cfg.error_limit});
        err     = err_raw;
        if (cfg.mode_flags[pidc_pkg::MODE_ERR_CLAMP])
        begin
            if (err >= err_lim)
            begin
                err = err_lim;
            end
            if (err <= -err_lim)
            begin
                err = -err_lim;
            end
        end
        abs_err  = err[pidc_pkg::ERR_W-1] ? unsigned'(-err) : unsigned'(err);
        err_diff = pidc_pkg::DIFF_W'(err) - pidc_pkg::DIFF_W'(prev_err_reg);
    end

    // Unsigned gains enter the signed multipliers with a zero sign bit.
    assign gain_p_s = $signed({1'b0, cfg.gain_p});
    assign gain_i_s = $signed({1'b0, cfg.gain_i});
    assign gain_d_s = $signed({1'b0, cfg.gain_d});

    // Three independent products, registered before any further arithmetic.
    always_comb
    begin
        prod_next.prod_p    = pidc_pkg::PROD_W'(gain_p_s) * pidc_pkg::PROD_W'(err);
        prod_next.prod_i    = pidc_pkg::PROD_W'(gain_i_s) * pidc_pkg::PROD_W'(err);
        prod_next.prod_d    = pidc_pkg::PROD_D_W'(gain_d_s) * pidc_pkg::PROD_D_W'(err_diff);
        prod_next.integrate = !(cfg.mode_flags[pidc_pkg::MODE_SEPARATION] &&
                                (abs_err > {2'b00, cfg.separation_band}));
        prev_err_next       = err;
    end

    // Sample and product registers.
    always_ff @(posedge clk)
    begin
        if (sample_load)
        begin
            setpoint_reg <= setpoint;
            measured_reg <= measured;
        end
        if (prod_load)
        begin
            prod_reg <= prod_next;
        end
    end

    // The previous error moves forward with each sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
        end
        else if (prod_load)
        begin
            prev_err_reg <= prev_err_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/pidc_integ_stage.sv =====
// Integral accumulator with saturation and clamp, and the scaled P plus D term.
module pidc_integ_stage #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  pidc_pkg::prod_t                      prod,
    input  pidc_pkg::cfg_t                       cfg,
    output logic signed [pidc_pkg::PD_W + ((FRAC_BITS >= pidc_pkg::GAIN_FRAC) ?
                          (FRAC_BITS - pidc_pkg::GAIN_FRAC) : 0)-1:0] pd_term,
    output logic signed [pidc_pkg::INTEG_W-1:0]  integral
);

    localparam int SH_UP   = (FRAC_BITS >= pidc_pkg::GAIN_FRAC) ?
                             (FRAC_BITS - pidc_pkg::GAIN_FRAC) : 0;
    localparam int SH_DN   = (FRAC_BITS < pidc_pkg::GAIN_FRAC) ?
                             (pidc_pkg::GAIN_FRAC - FRAC_BITS) : 0;
    localparam int PD_SC_W = pidc_pkg::PD_W + SH_UP;
    localparam int I_SC_W  = pidc_pkg::PROD_W + SH_UP;
    localparam int ACC_W   = I_SC_W + 1;

    localparam logic signed [pidc_pkg::INTEG_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [pidc_pkg::INTEG_W-1:0] INT_MIN = 32'sh8000_0000;

    logic signed [pidc_pkg::PD_W-1:0]    pd_sum;
    logic signed [PD_SC_W-1:0]           pd_sc;
    logic signed [I_SC_W-1:0]            i_sc;
    logic signed [ACC_W-1:0]             acc;
    logic signed [pidc_pkg::INTEG_W-1:0] acc_sat;
    logic signed [pidc_pkg::INTEG_W-1:0] int_lim;
    logic signed [PD_SC_W-1:0]           pd_reg;
    logic signed [PD_SC_W-1:0]           pd_next;
    logic signed [pidc_pkg::INTEG_W-1:0] integral_reg;
    logic signed [pidc_pkg::INTEG_W-1:0] integral_next;

    // Move the Q.8 products to the integral's fraction width (floor on right shift).
    always_comb
    begin
        pd_sum = pidc_pkg::PD_W'(prod.prod_p) + pidc_pkg::PD_W'(prod.prod_d);
        pd_sc  = (PD_SC_W'(pd_sum) <<< SH_UP) >>> SH_DN;
        i_sc   = (I_SC_W'(prod.prod_i) <<< SH_UP) >>> SH_DN;
    end

    // Accumulate or hold, saturate to 32 bits, then apply the optional integral clamp.
    always_comb
    begin
        acc = ACC_W'(i_sc) + ACC_W'(integral_reg);
        if (acc > ACC_W'(INT_MAX))
        begin
            acc_sat = INT_MAX;
        end
        else if (acc < ACC_W'(INT_MIN))
        begin
            acc_sat = INT_MIN;
        end
        else
        begin
            acc_sat = acc[pidc_pkg::INTEG_W-1:0];
        end

        integral_next = prod.integrate ? acc_sat : integral_reg;
        int_lim = $signed({1'b0, (31'(cfg.integral_limit) << FRAC_BITS)});
        if (cfg.mode_flags[pidc_pkg::MODE_INT_CLAMP])
        begin
            if (integral_next >= int_lim)
            begin
                integral_next = int_lim;
            end
            if (integral_next <= -int_lim)
            begin
                integral_next = -int_lim;
            end
        end
        pd_next = pd_sc;
    end

    // The P plus D term travels with the sample; it needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pd_reg <= pd_next;
        end
    end

    // Integral state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
        end
        else if (load)
        begin
            integral_reg <= integral_next;
        end
    end

    assign pd_term  = pd_reg;
    assign integral = integral_reg;

endmodule

// ===== src/pidc_out_stage.sv =====
// Output sum, output clamp and integer extraction of the PID controller.
module pidc_out_stage #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic signed [pidc_pkg::PD_W + ((FRAC_BITS >= pidc_pkg::GAIN_FRAC) ?
                          (FRAC_BITS - pidc_pkg::GAIN_FRAC) : 0)-1:0] pd_term,
    input  logic signed [pidc_pkg::INTEG_W-1:0]  integral,
    input  pidc_pkg::cfg_t                       cfg,
    output logic signed [pidc_pkg::SAMPLE_W-1:0] drive
);

    localparam int SH_UP   = (FRAC_BITS >= pidc_pkg::GAIN_FRAC) ?
                             (FRAC_BITS - pidc_pkg::GAIN_FRAC) : 0;
    localparam int PD_SC_W = pidc_pkg::PD_W + SH_UP;
    localparam int SUM_W   = PD_SC_W + 1;

    logic signed [SUM_W-1:0]              sum;
    logic signed [SUM_W-1:0]              out_lim;
    logic signed [pidc_pkg::SAMPLE_W-1:0] drive_reg;
    logic signed [pidc_pkg::SAMPLE_W-1:0] drive_next;

    // Sum the terms, clamp symmetrically and keep the floor of the integer part.
    always_comb
    begin
        sum     = SUM_W'(pd_term) + SUM_W'(integral);
        out_lim = $signed(SUM_W'(cfg.output_limit) << FRAC_BITS);
        if (sum >= out_lim)
        begin
            sum = out_lim;
        end
        if (sum <= -out_lim)
        begin
            sum = -out_lim;
        end
        drive_next = pidc_pkg::SAMPLE_W'(sum >>> FRAC_BITS);
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

// ===== src/pid_controller_clamped.sv =====
// Positional PID controller with error clamp, integral separation and clamps.
// One sample (setpoint, measured) goes in per transfer and one drive value comes
// out per sample, in order. The datapath is a four-register pipeline: sample
// register, gain-product register, integral/P+D register and result register,
// and drive is offered once its sample has reached the result register. The
// block takes one sample every cycle while the output side keeps ready high; the
// rate is set by the integral accumulate-saturate-clamp loop, which closes
// through the integral register alone. Ready passes back combinationally
// through every stage of the pipeline. Gains are
// unsigned Q8.8, the integral carries FRAC_BITS fraction bits, and drive is the
// floor of the clamped fixed-point sum. Configuration should be written while
// no sample is in flight.
module pid_controller_clamped #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [pidc_pkg::SAMPLE_W-1:0] setpoint,
    input  logic signed [pidc_pkg::SAMPLE_W-1:0] measured,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [pidc_pkg::SAMPLE_W-1:0] drive
);

    localparam int SH_UP   = (FRAC_BITS >= pidc_pkg::GAIN_FRAC) ?
                             (FRAC_BITS - pidc_pkg::GAIN_FRAC) : 0;
    localparam int PD_SC_W = pidc_pkg::PD_W + SH_UP;

    pidc_pkg::cfg_t                       cfg;
    pidc_pkg::prod_t                      prod;
    logic signed [PD_SC_W-1:0]            pd_term;
    logic signed [pidc_pkg::INTEG_W-1:0]  integral;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic ready2, ready3, ready4;
    logic load1, load2, load3, load4;

    // Each stage moves when the one after it is empty or moving.
    always_comb
    begin
        ready4   = !v4_reg || out_ready;
        ready3   = !v3_reg || ready4;
        ready2   = !v2_reg || ready3;
        in_ready = !v1_reg || ready2;

        load1 = in_valid && in_ready;
        load2 = v1_reg && ready2;
        load3 = v2_reg && ready3;
        load4 = v3_reg && ready4;

        v1_next = in_ready ? in_valid : v1_reg;
        v2_next = ready2   ? v1_reg   : v2_reg;
        v3_next = ready3   ? v2_reg   : v3_reg;
        v4_next = ready4   ? v3_reg   : v4_reg;
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign out_valid = v4_reg;

    pidc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidc_mult_stage u_mult_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_load (load1),
        .prod_load   (load2),
        .setpoint    (setpoint),
        .measured    (measured),
        .cfg         (cfg),
        .prod        (prod)
    );

    pidc_integ_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_integ_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load3),
        .prod     (prod),
        .cfg      (cfg),
        .pd_term  (pd_term),
        .integral (integral)
    );

    pidc_out_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out_stage (
        .clk      (clk),
        .load     (load4),
        .pd_term  (pd_term),
        .integral (integral),
        .cfg      (cfg),
        .drive    (drive)
    );

endmodule

// ===== src/pidc_checker.sv =====
// Port-level checks of the PID controller, bound to its top level.
module pidc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [pidc_pkg::SAMPLE_W-1:0] drive
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive))
    else $error("stalled drive result changed or was dropped");

    // With the output side ready the pipeline never blocks new samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
    else $error("input blocked while output side is ready");

    // A transfer reaches the result register when the output side stays ready in between.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing four cycles after input transfer");

    // No result is offered right after reset.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
);

// ===== dv/tb_pid_controller_clamped.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the clamped PID controller: directed table, then random phases.
module tb_pid_controller_clamped;

    localparam int FRAC_BITS      = 8;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int NUM_REGS       = 8;
    localparam int NUM_PHASES     = 10;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int PHASE_ITEMS    = RANDOM_ITEMS / NUM_PHASES;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 35;

    localparam longint INTEG_MAX  = (longint'(1) <<< (pidc_pkg::INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN  = -(longint'(1) <<< (pidc_pkg::INTEG_W - 1));
    localparam longint SAMPLE_MAX = (longint'(1) <<< (pidc_pkg::SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) <<< (pidc_pkg::SAMPLE_W - 1));

    // Output-side ready patterns.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE
    } stall_mode_t;

    // One row of the directed table: a register write or a sample.
    typedef struct packed {
        bit                                   is_write;
        pidc_pkg::reg_index_t                 idx;
        logic [pidc_pkg::CFG_DATA_W-1:0]      data;
        logic signed [pidc_pkg::SAMPLE_W-1:0] sp;
        logic signed [pidc_pkg::SAMPLE_W-1:0] ms;
        bit                                   typed;
        logic signed [pidc_pkg::SAMPLE_W-1:0] drv;
    } step_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 cfg_we;
    pidc_pkg::reg_index_t                 cfg_index;
    logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_data;
    logic                                 in_valid;
    logic                                 in_ready;
    logic signed [pidc_pkg::SAMPLE_W-1:0] setpoint;
    logic signed [pidc_pkg::SAMPLE_W-1:0] measured;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [pidc_pkg::SAMPLE_W-1:0] drive;

    // Controller state and settings as the testbench tracks them.
    pidc_pkg::cfg_t                       pid_cfg;
    logic signed [pidc_pkg::ERR_W-1:0]    last_error;
    logic signed [pidc_pkg::INTEG_W-1:0]  integral_acc;

    logic signed [pidc_pkg::SAMPLE_W-1:0] expected_drive [$];
    logic signed [pidc_pkg::SAMPLE_W-1:0] wanted_drive;
    logic signed [pidc_pkg::SAMPLE_W-1:0] corner_values [4] =
        '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    step_t                                directed_steps [DIRECTED_ROWS];

    int                                   mismatches   = 0;
    int                                   idle_cycles  = 0;
    int                                   burst_left   = 0;
    int                                   stall_left   = 0;
    stall_mode_t                          stall_mode   = READY_ALWAYS;

    pid_controller_clamped #(
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .setpoint  (setpoint),
        .measured  (measured),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Symmetric saturation; a zero bound forces zero.
    function automatic longint clamp_symmetric(longint value, longint bound);
        if (value >= bound)
        begin
            value = bound;
        end
        if (value <= -bound)
        begin
            value = -bound;
        end
        return value;
    endfunction

    // Move a product with eight fraction bits to FRAC_BITS fraction bits (floor).
    function automatic longint gain_to_frac(longint q8);
        if (FRAC_BITS >= pidc_pkg::GAIN_FRAC)
        begin
            return q8 <<< (FRAC_BITS - pidc_pkg::GAIN_FRAC);
        end
        return q8 >>> (pidc_pkg::GAIN_FRAC - FRAC_BITS);
    endfunction

    // Advance the tracked controller state by one sample and return its drive value.
    function automatic logic signed [pidc_pkg::SAMPLE_W-1:0] predict_drive(
        logic signed [pidc_pkg::SAMPLE_W-1:0] sp,
        logic signed [pidc_pkg::SAMPLE_W-1:0] ms
    );
        longint err;
        longint magnitude;
        longint acc;
        longint total;

        err = longint'(sp) - longint'(ms);
        if (pid_cfg.mode_flags[pidc_pkg::MODE_ERR_CLAMP])
        begin
            err = clamp_symmetric(err, longint'(pid_cfg.error_limit));
        end
        magnitude = (err < 0) ? -err : err;

        // Integrate unless separation is on and the error is outside the band.
        if (!(pid_cfg.mode_flags[pidc_pkg::MODE_SEPARATION] &&
              magnitude > longint'(pid_cfg.separation_band)))
        begin
            acc = longint'(integral_acc) + gain_to_frac(longint'(pid_cfg.gain_i) * err);
            if (acc > INTEG_MAX)
            begin
                acc = INTEG_MAX;
            end
            if (acc < INTEG_MIN)
            begin
                acc = INTEG_MIN;
            end
            integral_acc = pidc_pkg::INTEG_W'(acc);
        end
        if (pid_cfg.mode_flags[pidc_pkg::MODE_INT_CLAMP])
        begin
            integral_acc = pidc_pkg::INTEG_W'(clamp_symmetric(longint'(integral_acc),
                longint'(pid_cfg.integral_limit) <<< FRAC_BITS));
        end

        // Proportional and derivative terms plus the integral, then the output clamp.
        total = gain_to_frac(longint'(pid_cfg.gain_p) * err +
                             longint'(pid_cfg.gain_d) * (err - longint'(last_error)))
                + longint'(integral_acc);
        total = clamp_symmetric(total, longint'(pid_cfg.output_limit) <<< FRAC_BITS);
        last_error = pidc_pkg::ERR_W'(err);
        return pidc_pkg::SAMPLE_W'(total >>> FRAC_BITS);
    endfunction

    function automatic step_t write_row(pidc_pkg::reg_index_t idx,
                                        logic [pidc_pkg::CFG_DATA_W-1:0] data);
        step_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.idx      = idx;
        row.data     = data;
        return row;
    endfunction

    function automatic step_t sample_row(logic signed [pidc_pkg::SAMPLE_W-1:0] sp,
                                         logic signed [pidc_pkg::SAMPLE_W-1:0] ms);
        step_t row;
        row    = '0;
        row.sp = sp;
        row.ms = ms;
        return row;
    endfunction

    function automatic step_t known_row(logic signed [pidc_pkg::SAMPLE_W-1:0] sp,
                                        logic signed [pidc_pkg::SAMPLE_W-1:0] ms,
                                        logic signed [pidc_pkg::SAMPLE_W-1:0] drv);
        step_t row;
        row       = sample_row(sp, ms);
        row.typed = 1'b1;
        row.drv   = drv;
        return row;
    endfunction

    // Write one register once the pipeline has drained.
    task automatic write_register(pidc_pkg::reg_index_t idx,
                                  logic [pidc_pkg::CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_drive.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            pidc_pkg::REG_MODE_FLAGS:
                pid_cfg.mode_flags      = value[pidc_pkg::MODE_W-1:0];
            pidc_pkg::REG_ERROR_LIMIT:
                pid_cfg.error_limit     = value[pidc_pkg::LIMIT_W-1:0];
            pidc_pkg::REG_SEPARATION_BAND:
                pid_cfg.separation_band = value[pidc_pkg::LIMIT_W-1:0];
            pidc_pkg::REG_INTEGRAL_LIMIT:
                pid_cfg.integral_limit  = value[pidc_pkg::LIMIT_W-1:0];
            pidc_pkg::REG_GAIN_P:
                pid_cfg.gain_p          = value[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::REG_GAIN_I:
                pid_cfg.gain_i          = value[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::REG_GAIN_D:
                pid_cfg.gain_d          = value[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::REG_OUTPUT_LIMIT:
                pid_cfg.output_limit    = value[pidc_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one sample in bursts with random gaps, and record its expected drive.
    task automatic feed_sample(logic signed [pidc_pkg::SAMPLE_W-1:0] sp,
                               logic signed [pidc_pkg::SAMPLE_W-1:0] ms,
                               bit typed, logic signed [pidc_pkg::SAMPLE_W-1:0] drv);
        int gap;
        logic signed [pidc_pkg::SAMPLE_W-1:0] predicted;

        if (cfg_we)
        begin
            cfg_we <= 1'b0;
        end
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        setpoint <= sp;
        measured <= ms;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predicted = predict_drive(sp, ms);
        expected_drive.push_back(typed ? drv : predicted);
    endtask

    // Output side: check each transfer, then choose ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    $error("drive: expected nothing, actual %0d", drive);
                    mismatches++;
                end
                else
                begin
                    wanted_drive = expected_drive.pop_front();
                    if (drive !== wanted_drive)
                    begin
                        $error("drive: expected %0d, actual %0d", wanted_drive, drive);
                        mismatches++;
                    end
                end
            end
            if (stall_left == 0)
            begin
                case ($urandom_range(0, 3))
                    3:       stall_mode = READY_SPARSE;
                    2:       stall_mode = READY_HALF;
                    default: stall_mode = READY_ALWAYS;
                endcase
                stall_left = $urandom_range(8, 60);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                READY_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
                READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:      out_ready <= 1'b1;
            endcase
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("pid_controller_clamped regression: fail");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        int                                   sel;
        int                                   offset;
        longint                               shifted;
        bit                                   gain_reg;
        pidc_pkg::reg_index_t                 idx;
        logic [pidc_pkg::CFG_DATA_W-1:0]      value;
        logic signed [pidc_pkg::SAMPLE_W-1:0] sp;
        logic signed [pidc_pkg::SAMPLE_W-1:0] ms;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = pidc_pkg::REG_MODE_FLAGS;
        cfg_data  = '0;
        in_valid  = 1'b0;
        setpoint  = '0;
        measured  = '0;

        pid_cfg.mode_flags      = pidc_pkg::RST_MODE_FLAGS;
        pid_cfg.error_limit     = pidc_pkg::RST_ERROR_LIMIT;
        pid_cfg.separation_band = pidc_pkg::RST_SEPARATION_BAND;
        pid_cfg.integral_limit  = pidc_pkg::RST_INTEGRAL_LIMIT;
        pid_cfg.gain_p          = pidc_pkg::RST_GAIN_P;
        pid_cfg.gain_i          = pidc_pkg::RST_GAIN_I;
        pid_cfg.gain_d          = pidc_pkg::RST_GAIN_D;
        pid_cfg.output_limit    = pidc_pkg::RST_OUTPUT_LIMIT;
        last_error              = '0;
        integral_acc            = '0;

        // Directed table: reset settings, clamps, zero limits, separation, saturation.
        directed_steps = '{
            known_row(0, 0, 0),
            known_row(16'sh7FFF, 16'sh8000, 5000),
            known_row(16'sh8000, 16'sh7FFF, -5000),
            sample_row(100, 90),
            sample_row(-1, 0),
            write_row(pidc_pkg::REG_MODE_FLAGS, 16'hFFF9),
            sample_row(16'sh7FFF, 16'sh8000),
            write_row(pidc_pkg::REG_ERROR_LIMIT, 16'h0000),
            sample_row(1234, -4321),
            write_row(pidc_pkg::REG_MODE_FLAGS, 16'h0007),
            write_row(pidc_pkg::REG_ERROR_LIMIT, 16'hFFFF),
            write_row(pidc_pkg::REG_INTEGRAL_LIMIT, 16'h0000),
            known_row(5, 5, 0),
            sample_row(6, 5),
            write_row(pidc_pkg::REG_SEPARATION_BAND, 16'd100),
            write_row(pidc_pkg::REG_INTEGRAL_LIMIT, 16'hFFFF),
            write_row(pidc_pkg::REG_MODE_FLAGS, 16'h0006),
            sample_row(50, 0),
            sample_row(0, 200),
            write_row(pidc_pkg::REG_MODE_FLAGS, 16'h0000),
            write_row(pidc_pkg::REG_GAIN_I, 16'hFFFF),
            write_row(pidc_pkg::REG_GAIN_P, 16'hFFFF),
            write_row(pidc_pkg::REG_GAIN_D, 16'hFFFF),
            write_row(pidc_pkg::REG_OUTPUT_LIMIT, 16'hFFFF),
            known_row(16'sh7FFF, 16'sh8000, 32767),
            known_row(16'sh8000, 16'sh7FFF, -32767),
            sample_row(16'sh8000, 16'sh7FFF),
            write_row(pidc_pkg::REG_OUTPUT_LIMIT, 16'h0000),
            known_row(1000, -1000, 0),
            write_row(pidc_pkg::REG_GAIN_P, 16'h0000),
            write_row(pidc_pkg::REG_GAIN_I, 16'h0000),
            write_row(pidc_pkg::REG_GAIN_D, 16'h0000),
            write_row(pidc_pkg::REG_OUTPUT_LIMIT, 16'd5000),
            write_row(pidc_pkg::REG_MODE_FLAGS, 16'h0002),
            sample_row(300, 200)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_write)
            begin
                write_register(directed_steps[i].idx, directed_steps[i].data);
            end
            else
            begin
                feed_sample(directed_steps[i].sp, directed_steps[i].ms,
                            directed_steps[i].typed, directed_steps[i].drv);
            end
        end

        // Random phases: first all maximum, then all minimum, then mixed settings.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                idx      = pidc_pkg::reg_index_t'(r);
                gain_reg = idx inside {pidc_pkg::REG_GAIN_P, pidc_pkg::REG_GAIN_I,
                                       pidc_pkg::REG_GAIN_D};
                if (phase == 0)
                begin
                    value = 16'hFFFF;
                end
                else if (phase == 1)
                begin
                    value = gain_reg ? 16'h0000 :
                            (idx == pidc_pkg::REG_MODE_FLAGS) ? 16'hFFF8 : 16'h8000;
                end
                else
                begin
                    // Bits above a register's width are random and must be ignored.
                    value = 16'($urandom);
                    if (idx != pidc_pkg::REG_MODE_FLAGS)
                    begin
                        sel = $urandom_range(0, 9);
                        case (sel)
                            0: value[14:0] = '0;
                            1: value[14:0] = '1;
                            2, 3, 4, 5:
                            begin
                                value[14:0] = 15'($urandom_range(1, 2000));
                                if (gain_reg)
                                begin
                                    value[15] = 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                write_register(idx, value);
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(0, 9);
                sp  = pidc_pkg::SAMPLE_W'($urandom);
                if (sel < 2)
                begin
                    ms = pidc_pkg::SAMPLE_W'($urandom);
                end
                else if (sel == 2)
                begin
                    sp = corner_values[$urandom_range(0, 3)];
                    ms = corner_values[$urandom_range(0, 3)];
                end
                else
                begin
                    // Tracking sample: measurement near the setpoint.
                    offset  = int'($urandom_range(0, 1200)) - 600;
                    shifted = longint'(sp) - offset;
                    if (shifted > SAMPLE_MAX)
                    begin
                        shifted = SAMPLE_MAX;
                    end
                    if (shifted < SAMPLE_MIN)
                    begin
                        shifted = SAMPLE_MIN;
                    end
                    ms = pidc_pkg::SAMPLE_W'(shifted);
                end
                feed_sample(sp, ms, 1'b0, '0);
            end
        end

        // Drain the pipeline and watch for stray results.
        in_valid <= 1'b0;
        while (expected_drive.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("pid_controller_clamped regression: pass");
        end
        else
        begin
            $display("pid_controller_clamped regression: fail");
        end
        $finish;
    end

endmodule
